// ----- design/tgd_pkg.sv -----
package tgd_pkg;

    localparam int TICK_COUNT_WIDTH = 8;
    localparam int CFG_WIDTH        = 8;
    localparam int CFG_INDEX_WIDTH  = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHORT_PRESS  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SECOND_LONG  = 2'd2;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET  = 8'd80;
    localparam logic [CFG_WIDTH-1:0] SHORT_PRESS_RESET = 8'd30;
    localparam logic [CFG_WIDTH-1:0] SECOND_LONG_RESET = 8'd100;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRESSED,
        PH_WAIT_RELEASE,
        PH_RELEASED_SHORT,
        PH_SECOND_PRESS
    } phase_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] long_press_ticks;
        logic [CFG_WIDTH-1:0] short_press_ticks;
        logic [CFG_WIDTH-1:0] second_long_ticks;
    } cfg_t;

    typedef struct packed {
        logic click;
        logic long_press;
        logic click_long;
        logic combo_a;
        logic combo_b;
    } btn_event_t;

    typedef struct packed {
        logic power_pressed;
        logic up_pressed;
        logic down_pressed;
    } in_item_t;

    typedef struct packed {
        logic power_click;
        logic power_long;
        logic power_click_long;
        logic up_tap;
        logic up_long;
        logic up_tap_long;
        logic down_tap;
        logic down_long;
        logic down_tap_long;
        logic up_down_long;
        logic power_up_long;
        logic power_down_long;
    } out_item_t;

endpackage

// ----- design/three_button_gesture_decoder.sv -----
// Gesture decoder for a power, an up and a down button.
// Input channel: one item per timer tick, carrying the pressed level of each
// button (in_valid / in_stall / in_data). Output channel: one item per input
// item, twelve one-tick pulse flags for click, long press, click-then-long
// and the three two-button combos (out_valid / out_stall / out_data).
// An item accepted at one edge shows its result after that edge. Without
// a stall, throughput is one item per cycle; the three per-button phase
// machines are evaluated in a single combinational pass (power, up, down,
// each seeing the phase changes of the ones before it) into the state
// registers and the result register.
// While the receiver stalls a valid result, the register holds and in_stall is
// raised, so the next item waits; a result taken in the same cycle frees
// the register for a new item at once.
// Reset puts all buttons in idle with zero counts, clears the result valid
// flag and loads thresholds 80 (long), 30 (short), 100 (second long).
// Thresholds are written via cfg_write / cfg_index / cfg_data; the user must
// do so only while idle, which is not enforced; indexes above 2 are ignored.
module three_button_gesture_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  tgd_pkg::in_item_t                      in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output tgd_pkg::out_item_t                     out_data,
    input  logic                                   cfg_write,
    input  logic [tgd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tgd_pkg::CFG_WIDTH-1:0]          cfg_data
);
    import tgd_pkg::*;

    localparam int TW = TICK_COUNT_WIDTH;

    cfg_t        cfg_reg;
    phase_t      power_phase_reg, up_phase_reg, down_phase_reg;
    logic [TW-1:0] power_ticks_reg, up_ticks_reg, down_ticks_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    phase_t      power_phase_next, up_phase_next, down_phase_next;
    logic [TW-1:0] power_ticks_next, up_ticks_next, down_ticks_next;
    out_item_t   out_data_next;
    logic        out_valid_next;

    phase_t      p_step_phase, u_step_phase, d_step_phase;
    phase_t      u_after_p, d_after_p;
    phase_t      p_after_u, d_after_u;
    btn_event_t  power_evt, up_evt, down_evt;

    logic        in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // power runs first against the current phases
    tgd_button u_power (
        .phase      (power_phase_reg),
        .ticks      (power_ticks_reg),
        .level      (in_data.power_pressed),
        .partner_a  (up_phase_reg),
        .partner_b  (down_phase_reg),
        .cfg        (cfg_reg),
        .phase_next (p_step_phase),
        .ticks_next (power_ticks_next),
        .evt        (power_evt)
    );

    assign u_after_p = power_evt.combo_a ? PH_WAIT_RELEASE : up_phase_reg;
    assign d_after_p = power_evt.combo_b ? PH_WAIT_RELEASE : down_phase_reg;

    tgd_button u_up (
        .phase      (u_after_p),
        .ticks      (up_ticks_reg),
        .level      (in_data.up_pressed),
        .partner_a  (d_after_p),
        .partner_b  (p_step_phase),
        .cfg        (cfg_reg),
        .phase_next (u_step_phase),
        .ticks_next (up_ticks_next),
        .evt        (up_evt)
    );

    assign d_after_u = up_evt.combo_a ? PH_WAIT_RELEASE : d_after_p;
    assign p_after_u = up_evt.combo_b ? PH_WAIT_RELEASE : p_step_phase;

    tgd_button u_down (
        .phase      (d_after_u),
        .ticks      (down_ticks_reg),
        .level      (in_data.down_pressed),
        .partner_a  (u_step_phase),
        .partner_b  (p_after_u),
        .cfg        (cfg_reg),
        .phase_next (d_step_phase),
        .ticks_next (down_ticks_next),
        .evt        (down_evt)
    );

    assign down_phase_next  = d_step_phase;
    assign up_phase_next    = down_evt.combo_a ? PH_WAIT_RELEASE : u_step_phase;
    assign power_phase_next = down_evt.combo_b ? PH_WAIT_RELEASE : p_after_u;

    always_comb
    begin
        out_data_next.power_click      = power_evt.click;
        out_data_next.power_long       = power_evt.long_press;
        out_data_next.power_click_long = power_evt.click_long;
        out_data_next.up_tap           = up_evt.click;
        out_data_next.up_long          = up_evt.long_press;
        out_data_next.up_tap_long      = up_evt.click_long;
        out_data_next.down_tap         = down_evt.click;
        out_data_next.down_long        = down_evt.long_press;
        out_data_next.down_tap_long    = down_evt.click_long;
        out_data_next.up_down_long     = up_evt.combo_a | down_evt.combo_a;
        out_data_next.power_up_long    = power_evt.combo_a | up_evt.combo_b;
        out_data_next.power_down_long  = power_evt.combo_b | down_evt.combo_b;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= LONG_PRESS_RESET;
            cfg_reg.short_press_ticks <= SHORT_PRESS_RESET;
            cfg_reg.second_long_ticks <= SECOND_LONG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:  cfg_reg.long_press_ticks  <= cfg_data;
                CFG_SHORT_PRESS: cfg_reg.short_press_ticks <= cfg_data;
                CFG_SECOND_LONG: cfg_reg.second_long_ticks <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_phase_reg <= PH_IDLE;
            up_phase_reg    <= PH_IDLE;
            down_phase_reg  <= PH_IDLE;
            power_ticks_reg <= '0;
            up_ticks_reg    <= '0;
            down_ticks_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                power_phase_reg <= power_phase_next;
                up_phase_reg    <= up_phase_next;
                down_phase_reg  <= down_phase_next;
                power_ticks_reg <= power_ticks_next;
                up_ticks_reg    <= up_ticks_next;
                down_ticks_reg  <= down_ticks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_state_holds_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(power_phase_reg) && $stable(up_phase_reg)
                        && $stable(down_phase_reg) && $stable(power_ticks_reg)
                        && $stable(up_ticks_reg) && $stable(down_ticks_reg)))
        else $error("button state moved without an item");

    a_power_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({out_data_reg.power_click, out_data_reg.power_long,
                                    out_data_reg.power_click_long}))
        else $error("power button raised more than one gesture");

    a_idle_release_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && power_phase_reg == PH_IDLE && !in_data.power_pressed)
        |=> ($stable(power_ticks_reg) && power_phase_reg == PH_IDLE))
        else $error("idle power button changed without a press");
`endif

endmodule

// ----- design/tgd_button.sv -----
module tgd_button (
    input  tgd_pkg::phase_t                            phase,
    input  logic [tgd_pkg::TICK_COUNT_WIDTH-1:0]       ticks,
    input  logic                                       level,
    input  tgd_pkg::phase_t                            partner_a,
    input  tgd_pkg::phase_t                            partner_b,
    input  tgd_pkg::cfg_t                              cfg,
    output tgd_pkg::phase_t                            phase_next,
    output logic [tgd_pkg::TICK_COUNT_WIDTH-1:0]       ticks_next,
    output tgd_pkg::btn_event_t                        evt
);
    import tgd_pkg::*;

    localparam int TW    = TICK_COUNT_WIDTH;
    localparam int CMP_W = (TW > CFG_WIDTH) ? TW : CFG_WIDTH;

    logic [TW-1:0]    ticks_inc;
    logic [CMP_W-1:0] ticks_cmp;
    logic [CMP_W-1:0] long_cmp;
    logic [CMP_W-1:0] short_cmp;
    logic [CMP_W-1:0] second_cmp;

    // saturating count, never wraps
    assign ticks_inc  = (ticks == {TW{1'b1}}) ? ticks : ticks + 1'b1;
    assign ticks_cmp  = CMP_W'(ticks_inc);
    assign long_cmp   = CMP_W'(cfg.long_press_ticks);
    assign short_cmp  = CMP_W'(cfg.short_press_ticks);
    assign second_cmp = CMP_W'(cfg.second_long_ticks);

    always_comb
    begin
        phase_next = phase;
        ticks_next = ticks;
        evt        = '0;
        case (phase)
            PH_IDLE:
            begin
                if (level)
                begin
                    ticks_next = '0;
                    phase_next = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                ticks_next = ticks_inc;
                if (ticks_cmp > long_cmp)
                begin
                    // a partner still in its pressed phase turns this into a combo
                    if (partner_a == PH_PRESSED)
                        evt.combo_a = 1'b1;
                    else if (partner_b == PH_PRESSED)
                        evt.combo_b = 1'b1;
                    else
                        evt.long_press = 1'b1;
                    phase_next = PH_WAIT_RELEASE;
                end
                else if (!level)
                begin
                    if (ticks_cmp < short_cmp)
                    begin
                        ticks_next = '0;
                        phase_next = PH_RELEASED_SHORT;
                    end
                    else
                    begin
                        evt.click  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_WAIT_RELEASE:
            begin
                if (!level)
                    phase_next = PH_IDLE;
            end
            PH_RELEASED_SHORT:
            begin
                ticks_next = ticks_inc;
                if (level)
                begin
                    ticks_next = '0;
                    phase_next = PH_SECOND_PRESS;
                end
                else if (ticks_cmp > short_cmp)
                begin
                    evt.click  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_SECOND_PRESS:
            begin
                ticks_next = ticks_inc;
                if (ticks_cmp > second_cmp)
                begin
                    evt.click_long = 1'b1;
                    phase_next     = PH_WAIT_RELEASE;
                end
                else if (!level)
                begin
                    evt.click  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import tgd_pkg::*;

    localparam int BTN_POWER = 0;
    localparam int BTN_UP    = 1;
    localparam int BTN_DOWN  = 2;

    localparam int COMBO_UP_DOWN    = 0;
    localparam int COMBO_POWER_UP   = 1;
    localparam int COMBO_POWER_DOWN = 2;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    // index 3 decodes to no register
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    localparam int OUT_BITS      = $bits(out_item_t);
    localparam int RESET_ROWS    = 4;
    localparam int DIRECTED_ROWS = 21;
    localparam int HOLD_OFF_CYCLES = 120;

    typedef struct {
        in_item_t  levels;
        int        reps;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_stall;
    in_item_t                   in_data = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    out_item_t                  out_data;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;

    // predictor state
    phase_t                      btn_phase [3];
    logic [TICK_COUNT_WIDTH-1:0] btn_ticks [3];
    logic [CFG_WIDTH-1:0]        thr_long;
    logic [CFG_WIDTH-1:0]        thr_short;
    logic [CFG_WIDTH-1:0]        thr_second;

    out_item_t expected_q [$];
    int        fail_count = 0;

    // sender and random gesture state
    int         burst_left = 0;
    int         run_left [3];
    logic [2:0] level_now;
    bit         hold_off_req = 1'b0;

    stim_row_t directed [DIRECTED_ROWS];

    // bit k of out_item_t, LSB first
    string field_name [OUT_BITS] = '{
        "power_down_long", "power_up_long", "up_down_long",
        "down_tap_long", "down_long", "down_tap",
        "up_tap_long", "up_long", "up_tap",
        "power_click_long", "power_long", "power_click"
    };

    three_button_gesture_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [TICK_COUNT_WIDTH-1:0] sat_inc(
        input logic [TICK_COUNT_WIDTH-1:0] t
    );
        if (t != '1)
            return t + 1'b1;
        return t;
    endfunction

    // One timer tick through the three button machines, in power, up, down order.
    function automatic out_item_t decode_tick(input in_item_t x);
        logic [2:0] lvl;
        logic [2:0] click;
        logic [2:0] held_long;
        logic [2:0] click_long;
        logic [2:0] combo;
        int         pa;
        int         pb;
        int         ca;
        int         cb;
        out_item_t  r;
        lvl = {x.down_pressed, x.up_pressed, x.power_pressed};
        click = '0;
        held_long = '0;
        click_long = '0;
        combo = '0;
        for (int b = 0; b < 3; b++)
        begin
            case (b)
                BTN_POWER:
                begin
                    pa = BTN_UP;   ca = COMBO_POWER_UP;
                    pb = BTN_DOWN; cb = COMBO_POWER_DOWN;
                end
                BTN_UP:
                begin
                    pa = BTN_DOWN;  ca = COMBO_UP_DOWN;
                    pb = BTN_POWER; cb = COMBO_POWER_UP;
                end
                default:
                begin
                    pa = BTN_UP;    ca = COMBO_UP_DOWN;
                    pb = BTN_POWER; cb = COMBO_POWER_DOWN;
                end
            endcase
            case (btn_phase[b])
                PH_IDLE:
                begin
                    if (lvl[b])
                    begin
                        btn_ticks[b] = '0;
                        btn_phase[b] = PH_PRESSED;
                    end
                end
                PH_PRESSED:
                begin
                    btn_ticks[b] = sat_inc(btn_ticks[b]);
                    if (btn_ticks[b] > thr_long)
                    begin
                        if (btn_phase[pa] == PH_PRESSED)
                        begin
                            combo[ca] = 1'b1;
                            btn_phase[pa] = PH_WAIT_RELEASE;
                        end
                        else if (btn_phase[pb] == PH_PRESSED)
                        begin
                            combo[cb] = 1'b1;
                            btn_phase[pb] = PH_WAIT_RELEASE;
                        end
                        else
                            held_long[b] = 1'b1;
                        btn_phase[b] = PH_WAIT_RELEASE;
                    end
                    else if (!lvl[b])
                    begin
                        if (btn_ticks[b] < thr_short)
                        begin
                            btn_ticks[b] = '0;
                            btn_phase[b] = PH_RELEASED_SHORT;
                        end
                        else
                        begin
                            click[b] = 1'b1;
                            btn_phase[b] = PH_IDLE;
                        end
                    end
                end
                PH_WAIT_RELEASE:
                begin
                    if (!lvl[b])
                        btn_phase[b] = PH_IDLE;
                end
                PH_RELEASED_SHORT:
                begin
                    btn_ticks[b] = sat_inc(btn_ticks[b]);
                    if (lvl[b])
                    begin
                        btn_ticks[b] = '0;
                        btn_phase[b] = PH_SECOND_PRESS;
                    end
                    else if (btn_ticks[b] > thr_short)
                    begin
                        click[b] = 1'b1;
                        btn_phase[b] = PH_IDLE;
                    end
                end
                PH_SECOND_PRESS:
                begin
                    btn_ticks[b] = sat_inc(btn_ticks[b]);
                    if (btn_ticks[b] > thr_second)
                    begin
                        click_long[b] = 1'b1;
                        btn_phase[b] = PH_WAIT_RELEASE;
                    end
                    else if (!lvl[b])
                    begin
                        click[b] = 1'b1;
                        btn_phase[b] = PH_IDLE;
                    end
                end
                default:
                    btn_phase[b] = PH_IDLE;
            endcase
        end
        r.power_click      = click[BTN_POWER];
        r.power_long       = held_long[BTN_POWER];
        r.power_click_long = click_long[BTN_POWER];
        r.up_tap           = click[BTN_UP];
        r.up_long          = held_long[BTN_UP];
        r.up_tap_long      = click_long[BTN_UP];
        r.down_tap         = click[BTN_DOWN];
        r.down_long        = held_long[BTN_DOWN];
        r.down_tap_long    = click_long[BTN_DOWN];
        r.up_down_long     = combo[COMBO_UP_DOWN];
        r.power_up_long    = combo[COMBO_POWER_UP];
        r.power_down_long  = combo[COMBO_POWER_DOWN];
        return r;
    endfunction

    // Hold length for the next level run, mostly near the current thresholds.
    function automatic int pick_run();
        int tl;
        int ts;
        int t2;
        tl = int'(thr_long);
        ts = int'(thr_short);
        t2 = int'(thr_second);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, ts + 2);
            4, 5:       return $urandom_range((tl > 1) ? tl - 1 : 1, tl + 2);
            6, 7:       return $urandom_range((t2 > 1) ? t2 - 1 : 1, t2 + 3);
            8:          return $urandom_range(1, 3);
            default:    return $urandom_range(1, tl + t2 + 4);
        endcase
    endfunction

    task automatic send_tick(input in_item_t x, input bit typed, input out_item_t typed_want);
        out_item_t want;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = decode_tick(x);
        expected_q.push_back(typed ? typed_want : want);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_LONG_PRESS:  thr_long = val;
            CFG_SHORT_PRESS: thr_short = val;
            CFG_SECOND_LONG: thr_second = val;
            default: ;
        endcase
    endtask

    task automatic load_thresholds(input logic [CFG_WIDTH-1:0] t_long,
                                   input logic [CFG_WIDTH-1:0] t_short,
                                   input logic [CFG_WIDTH-1:0] t_second);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(CFG_LONG_PRESS, t_long);
        write_reg(CFG_UNUSED, CFG_WIDTH'($urandom));
        write_reg(CFG_SHORT_PRESS, t_short);
        write_reg(CFG_SECOND_LONG, t_second);
        cfg_write <= 1'b0;
    endtask

    task automatic run_random(input int count);
        in_item_t   x;
        logic [2:0] lv;
        int         mate;
        for (int n = 0; n < count; n++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if (run_left[b] == 0)
                begin
                    level_now[b] = ~level_now[b];
                    run_left[b] = pick_run();
                    // pull a released button down with this one to reach the combos
                    if (level_now[b] && $urandom_range(0, 3) == 0)
                    begin
                        mate = (b + $urandom_range(1, 2)) % 3;
                        if (!level_now[mate])
                        begin
                            level_now[mate] = 1'b1;
                            run_left[mate] = run_left[b] + $urandom_range(0, 2);
                        end
                    end
                end
                run_left[b]--;
            end
            lv = level_now;
            // occasional one-tick glitch on a single button
            if ($urandom_range(0, 19) == 0)
            begin
                mate = $urandom_range(0, 2);
                lv[mate] = ~lv[mate];
            end
            x.power_pressed = lv[BTN_POWER];
            x.up_pressed    = lv[BTN_UP];
            x.down_pressed  = lv[BTN_DOWN];
            send_tick(x, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        logic [OUT_BITS-1:0] got;
        logic [OUT_BITS-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = out_data;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result %b with nothing expected", $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                for (int k = 0; k < OUT_BITS; k++)
                    if (got[k] !== want[k])
                    begin
                        $display("%0t: %s expected %b actual %b",
                                 $time, field_name[k], want[k], got[k]);
                        fail_count++;
                    end
            end
        end
    end

    // receiver: stall modes of random length, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold;
        mode = STALL_NONE;
        mode_left = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                    default:     out_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        #400000;
        $display("three_button_gesture_decoder test failed");
        $finish;
    end

    initial
    begin
        for (int b = 0; b < 3; b++)
        begin
            btn_phase[b] = PH_IDLE;
            btn_ticks[b] = '0;
            run_left[b] = 0;
        end
        level_now = '0;
        thr_long = LONG_PRESS_RESET;
        thr_short = SHORT_PRESS_RESET;
        thr_second = SECOND_LONG_RESET;

        // first rows run at reset thresholds, the rest at 2/2/2
        directed = '{
            '{3'b000, 1, 1'b1, 12'h000},
            '{3'b111, 1, 1'b1, 12'h000},
            '{3'b000, 1, 1'b1, 12'h000},
            '{3'b000, 1, 1'b1, 12'h000},
            '{3'b000, 2, 1'b0, 12'h000},
            '{3'b100, 4, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b110, 4, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b101, 4, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b011, 4, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b001, 1, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b001, 4, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b010, 2, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000},
            '{3'b111, 4, 1'b0, 12'h000},
            '{3'b000, 1, 1'b0, 12'h000}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == RESET_ROWS)
                load_thresholds(8'd2, 8'd2, 8'd2);
            repeat (directed[i].reps)
                send_tick(directed[i].levels, directed[i].typed, directed[i].want);
        end

        load_thresholds(LONG_PRESS_RESET, SHORT_PRESS_RESET, SECOND_LONG_RESET);
        run_random(120);
        load_thresholds(8'd0, 8'd0, 8'd0);
        run_random(60);
        load_thresholds(8'd1, 8'd1, 8'd1);
        run_random(80);
        load_thresholds(8'd3, 8'd2, 8'd4);
        hold_off_req = 1'b1;
        run_random(120);
        load_thresholds(CFG_WIDTH'($urandom_range(2, 12)), CFG_WIDTH'($urandom_range(2, 12)),
                        CFG_WIDTH'($urandom_range(2, 12)));
        run_random(100);
        // counters saturate at these thresholds and never pass them
        load_thresholds(8'd255, 8'd255, 8'd255);
        run_random(120);
        load_thresholds(8'd1, 8'd254, 8'd0);
        run_random(60);

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && expected_q.size() == 0)
            $display("three_button_gesture_decoder test passed");
        else
            $display("three_button_gesture_decoder test failed");
        $finish;
    end

endmodule

// ----- three_button_gesture_decoder.f -----
design/tgd_pkg.sv
design/tgd_button.sv
design/three_button_gesture_decoder.sv
tb/testbench.sv
